@@ hw/rtl/firct_pkg.sv @@
`timescale 1ns / 1ps

package firct_pkg;

    // configuration register map
    localparam int NUM_COEF     = 6;
    localparam int COEF_BITS    = 16;
    localparam int COEF_FRAC    = 15;
    localparam int CFG_IDX_BITS = 3;
    localparam int TAP_CNT_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_COEF0     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_USED = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONV_MODE = 3'd7;

    // reset values
    localparam logic signed [COEF_BITS-1:0] COEF0_RESET     = 16'sh7FFF;
    localparam logic [TAP_CNT_BITS-1:0]     TAPS_USED_RESET = 3'd6;

    // default build
    localparam int TAPS_DEFAULT        = 6;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    typedef struct packed {
        logic [TAP_CNT_BITS-1:0] eff_taps;
        logic                    conv_mode;
    } ctrl_t;

endpackage

@@ hw/rtl/firct_cfg.sv @@
`timescale 1ns / 1ps

module firct_cfg #(
    parameter int TAPS = firct_pkg::TAPS_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [firct_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [firct_pkg::COEF_BITS-1:0]          cfg_wdata,
    output logic signed [firct_pkg::COEF_BITS-1:0]   coef [(TAPS < firct_pkg::NUM_COEF) ?
                                                            TAPS : firct_pkg::NUM_COEF],
    output firct_pkg::ctrl_t                         ctrl
);

    localparam int LIM = (TAPS < firct_pkg::NUM_COEF) ? TAPS : firct_pkg::NUM_COEF;
    localparam logic [firct_pkg::TAP_CNT_BITS-1:0] LIM_CNT = firct_pkg::TAP_CNT_BITS'(LIM);

    logic signed [firct_pkg::COEF_BITS-1:0] coef_reg [LIM];
    logic [firct_pkg::TAP_CNT_BITS-1:0]     taps_used_reg;
    logic                                   conv_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIM; i++)
            begin
                coef_reg[i] <= (i == 0) ? firct_pkg::COEF0_RESET : '0;
            end
            taps_used_reg <= firct_pkg::TAPS_USED_RESET;
            conv_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            // coefficient slots past the filter length are dropped
            for (int i = 0; i < LIM; i++)
            begin
                if (cfg_index == firct_pkg::CFG_IDX_BITS'(firct_pkg::REG_COEF0 + i))
                begin
                    coef_reg[i] <= cfg_wdata;
                end
            end
            if (cfg_index == firct_pkg::REG_TAPS_USED)
            begin
                taps_used_reg <= cfg_wdata[firct_pkg::TAP_CNT_BITS-1:0];
            end
            if (cfg_index == firct_pkg::REG_CONV_MODE)
            begin
                conv_mode_reg <= cfg_wdata[0];
            end
        end
    end

    assign coef = coef_reg;

    // tap count clamped to 1..LIM
    always_comb
    begin
        if (taps_used_reg == '0)
        begin
            ctrl.eff_taps = firct_pkg::TAP_CNT_BITS'(1);
        end
        else if (taps_used_reg > LIM_CNT)
        begin
            ctrl.eff_taps = LIM_CNT;
        end
        else
        begin
            ctrl.eff_taps = taps_used_reg;
        end
        ctrl.conv_mode = conv_mode_reg;
    end

`ifndef SYNTHESIS
    a_eff_taps_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.eff_taps != '0 && ctrl.eff_taps <= LIM_CNT)
        else $error("effective tap count out of range");
`endif

endmodule

@@ hw/rtl/fir_filter_with_conv_tail_core.sv @@
`timescale 1ns / 1ps

// direct-form fir filter, up to six q1.15 taps, with optional convolution tail
// input stream  s_*: one sample word per beat, s_tlast marks the last sample of a block
// output stream m_*: one filtered word per beat, m_tlast on the final word of a block
// config port: cfg_we writes cfg_wdata into register cfg_index (coef0..5, taps_used,
//   full_conv_mode); write only while the filter is idle
// pipeline: the sample is taken into the product register, then sum / round / saturate
//   feed the output register that drives m_tvalid and m_tdata
// throughput: one word per cycle in both directions while m_tready stays high; in convolution
//   mode a block end holds s_tready low while the taps-1 flush words are generated
// the tap products are computed in parallel, one multiplier per tap, so the rate is
//   set by the single pass through those multipliers and the adder that follows
// reset: history cleared, coef0 = 0x7fff, other taps zero, six taps, truncated mode,
//   pipeline empty
// stall: when m_tready is low the output word holds, the product stage still fills,
//   and s_tready drops once both stages are occupied; nothing is dropped
module fir_filter_with_conv_tail_core #(
    parameter int TAPS        = firct_pkg::TAPS_DEFAULT,
    parameter int SAMPLE_BITS = firct_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    input  logic                                    s_tlast,    // block_end
    // output stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    output logic                                    m_tlast,    // run_last
    // configuration write port
    input  logic                                    cfg_we,
    input  logic [firct_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [firct_pkg::COEF_BITS-1:0]         cfg_wdata
);

    localparam int LIM     = (TAPS < firct_pkg::NUM_COEF) ? TAPS : firct_pkg::NUM_COEF;
    localparam int HIST    = LIM - 1;
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PW      = SAMPLE_BITS + firct_pkg::COEF_BITS;   // one product
    localparam int SW      = PW + 3;                               // sum of up to six
    localparam int QW      = SW - firct_pkg::COEF_FRAC;            // after the shift
    localparam int CW      = firct_pkg::TAP_CNT_BITS;

    localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (firct_pkg::COEF_FRAC - 1);
    localparam logic signed [QW-1:0] Q_MAX = {{(QW - SAMPLE_BITS + 1){1'b0}},
                                              {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {{(QW - SAMPLE_BITS + 1){1'b1}},
                                              {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [firct_pkg::COEF_BITS-1:0] coef [LIM];
    firct_pkg::ctrl_t                       ctrl;

    firct_cfg #(
        .TAPS (TAPS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coef      (coef),
        .ctrl      (ctrl)
    );

    // delay line and flush counter
    logic signed [SAMPLE_BITS-1:0] hist_reg [HIST];
    logic [CW-1:0]                 tail_left_reg;

    // product stage
    logic                          p_valid_reg;
    logic                          p_last_reg;
    logic signed [PW-1:0]          prod_reg [LIM];

    // output stage
    logic                          o_valid_reg;
    logic                          o_last_reg;
    logic [SAMPLE_BITS-1:0]        o_sample_reg;

    logic                          o_take;
    logic                          p_take;
    logic                          tail_busy;
    logic                          in_fire;
    logic                          tail_fire;
    logic                          front_fire;
    logic                          front_last;
    logic [CW-1:0]                 tail_load;
    logic [CW-1:0]                 tail_left_next;
    logic signed [SAMPLE_BITS-1:0] front_x;
    logic signed [SAMPLE_BITS-1:0] tap_x [LIM];
    logic signed [PW-1:0]          prod_next [LIM];
    logic signed [SW-1:0]          acc;
    logic signed [QW-1:0]          q;
    logic [SAMPLE_BITS-1:0]        sat;

    // handshake: each stage moves when the one after it is free or moving
    assign o_take     = !o_valid_reg || m_tready;
    assign p_take     = !p_valid_reg || o_take;
    assign tail_busy  = (tail_left_reg != '0);
    assign s_tready   = !tail_busy && p_take;
    assign in_fire    = s_tvalid && s_tready;
    assign tail_fire  = tail_busy && p_take;
    assign front_fire = in_fire || tail_fire;

    // flush words push zeros through the delay line
    assign front_x   = tail_busy ? '0 : s_tdata[SAMPLE_BITS-1:0];
    assign tail_load = (s_tlast && ctrl.conv_mode) ? CW'(ctrl.eff_taps - CW'(1)) : '0;
    assign front_last = tail_busy ? (tail_left_reg == CW'(1))
                                  : (s_tlast && tail_load == '0);

    always_comb
    begin
        tail_left_next = tail_left_reg;
        if (in_fire)
        begin
            tail_left_next = tail_load;
        end
        else if (tail_fire)
        begin
            tail_left_next = CW'(tail_left_reg - CW'(1));
        end
    end

    // one multiplier per tap, taps past the count in use contribute zero
    always_comb
    begin
        tap_x[0] = front_x;
        for (int k = 1; k < LIM; k++)
        begin
            tap_x[k] = hist_reg[k-1];
        end
        for (int k = 0; k < LIM; k++)
        begin
            if (CW'(k) < ctrl.eff_taps)
            begin
                prod_next[k] = PW'(coef[k]) * PW'(tap_x[k]);
            end
            else
            begin
                prod_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST; i++)
            begin
                hist_reg[i] <= '0;
            end
            tail_left_reg <= '0;
        end
        else
        begin
            tail_left_reg <= tail_left_next;
            if (front_fire)
            begin
                // the word that closes a block leaves the delay line empty
                if (front_last)
                begin
                    for (int i = 0; i < HIST; i++)
                    begin
                        hist_reg[i] <= '0;
                    end
                end
                else
                begin
                    hist_reg[0] <= front_x;
                    for (int i = 1; i < HIST; i++)
                    begin
                        hist_reg[i] <= hist_reg[i-1];
                    end
                end
            end
        end
    end

    // product stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_take)
        begin
            p_valid_reg <= front_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_take && front_fire)
        begin
            prod_reg   <= prod_next;
            p_last_reg <= front_last;
        end
    end

    // sum, round half up, saturate
    always_comb
    begin
        acc = HALF_LSB;
        for (int k = 0; k < LIM; k++)
        begin
            acc = acc + SW'(prod_reg[k]);
        end
        q = QW'(acc >>> firct_pkg::COEF_FRAC);
        if (q > Q_MAX)
        begin
            sat = Q_MAX[SAMPLE_BITS-1:0];
        end
        else if (q < Q_MIN)
        begin
            sat = Q_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = q[SAMPLE_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_take)
        begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_take && p_valid_reg)
        begin
            o_sample_reg <= sat;
            o_last_reg   <= p_last_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = TDATA_W'(o_sample_reg);
    assign m_tlast  = o_last_reg;

`ifndef SYNTHESIS
    a_trunc_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_tlast && !ctrl.conv_mode |=> hist_reg[0] == '0)
        else $error("delay line not cleared after block end");

    a_tail_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        tail_left_reg != '0 |=> tail_left_reg == CW'($past(tail_left_reg) - CW'(1))
                                || tail_left_reg == $past(tail_left_reg))
        else $error("flush counter skipped a step");

    a_tail_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tail_left_reg < ctrl.eff_taps)
        else $error("flush counter exceeds tap count");
`endif

endmodule
